// ===== design/hsvrgb_pkg.sv =====
// Package for the fixed-point HSV to RGB converter.
// Holds the scale constants and the sector codes; no dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Input scale: level and saturation reach full at this step
    localparam int unsigned SCALE_MAX    = 254;
    // Hue steps in one sector of the colour circle
    localparam int unsigned SECTOR_STEPS = 42;
    // Hue byte that enhanced mode folds to zero
    localparam logic [7:0]  HUE_FOLD     = 8'hFF;

    // Sector codes, hue / 42 with the tail of the circle folded into the last
    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_0    = 3'd0;
    localparam sector_t SECTOR_1    = 3'd1;
    localparam sector_t SECTOR_2    = 3'd2;
    localparam sector_t SECTOR_3    = 3'd3;
    localparam sector_t SECTOR_4    = 3'd4;
    localparam sector_t SECTOR_5    = 3'd5;
    localparam sector_t SECTOR_TAIL = 3'd6;

endpackage

// ===== design/hsvrgb_front.sv =====
// First pipeline stage: hue selection, sector split and table lookups.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_front
    import hsvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 15
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [15:0]              hue_in,
    input  logic                     enhanced,
    input  logic [7:0]               sat_in,
    input  logic [7:0]               level,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRACTION_BITS:0]   v_val,
    output logic [FRACTION_BITS:0]   s_val,
    output logic [FRACTION_BITS:0]   f_val,
    output sector_t                  sector,
    output logic [7:0]               hue
);

    localparam int          UW  = FRACTION_BITS + 1;
    localparam int unsigned ONE = 1 << FRACTION_BITS;

    logic [UW-1:0] unit_lut [0:255];
    logic [UW-1:0] frac_lut [0:63];

    // Build the 254-step to Q1.FRACTION_BITS table, clamped at full
    for (genvar i = 0; i < 256; i++)
    begin : g_unit
        localparam int unsigned RAW = (i * ONE) / SCALE_MAX;
        assign unit_lut[i] = UW'((RAW > ONE) ? ONE : RAW);
    end

    // Build the in-sector fraction table; codes past the sector width read zero
    for (genvar j = 0; j < 64; j++)
    begin : g_frac
        localparam int unsigned FR = (j < SECTOR_STEPS) ? (j * ONE) / SECTOR_STEPS : 0;
        assign frac_lut[j] = UW'(FR);
    end

    logic [7:0]    hue_sel;
    sector_t       raw_sector;
    sector_t       sector_next;
    logic [7:0]    sector_base;
    logic [7:0]    rem_full;
    logic          en;

    logic          valid_reg;
    logic [UW-1:0] v_reg;
    logic [UW-1:0] s_reg;
    logic [UW-1:0] f_reg;
    sector_t       sector_reg;
    logic [7:0]    hue_reg;

    // Pick the hue byte for the mode in use
    always_comb
    begin
        if (enhanced)
        begin
            hue_sel = (hue_in[15:8] == HUE_FOLD) ? 8'd0 : hue_in[15:8];
        end
        else
        begin
            hue_sel = hue_in[7:0];
        end
    end

    // Split the hue into sector and remainder
    always_comb
    begin
        priority if (hue_sel >= 8'd252)
            raw_sector = SECTOR_TAIL;
        else if (hue_sel >= 8'd210)
            raw_sector = SECTOR_5;
        else if (hue_sel >= 8'd168)
            raw_sector = SECTOR_4;
        else if (hue_sel >= 8'd126)
            raw_sector = SECTOR_3;
        else if (hue_sel >= 8'd84)
            raw_sector = SECTOR_2;
        else if (hue_sel >= 8'd42)
            raw_sector = SECTOR_1;
        else
            raw_sector = SECTOR_0;
    end

    always_comb
    begin
        sector_base = 8'(raw_sector * SECTOR_STEPS);
        rem_full    = hue_sel - sector_base;
        sector_next = (raw_sector == SECTOR_TAIL) ? SECTOR_5 : raw_sector;
    end

    // Advance when the stage is empty or its contents move on
    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            v_reg      <= unit_lut[level];
            s_reg      <= unit_lut[sat_in];
            f_reg      <= frac_lut[rem_full[5:0]];
            sector_reg <= sector_next;
            hue_reg    <= hue_sel;
        end
    end

    assign out_valid = valid_reg;
    assign v_val     = v_reg;
    assign s_val     = s_reg;
    assign f_val     = f_reg;
    assign sector    = sector_reg;
    assign hue       = hue_reg;

endmodule

// ===== design/hsvrgb_terms.sv =====
// Two multiplier stages that form the p, q and t terms.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_terms
    import hsvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 15
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FRACTION_BITS:0]   v_val,
    input  logic [FRACTION_BITS:0]   s_val,
    input  logic [FRACTION_BITS:0]   f_val,
    input  sector_t                  sector,
    input  logic [7:0]               hue,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FRACTION_BITS:0]   v_term,
    output logic [FRACTION_BITS:0]   p_term,
    output logic [FRACTION_BITS:0]   q_term,
    output logic [FRACTION_BITS:0]   t_term,
    output sector_t                  sector_out,
    output logic [7:0]               hue_out
);

    localparam int          UW  = FRACTION_BITS + 1;
    localparam logic [UW-1:0] ONE = UW'(1) << FRACTION_BITS;

    logic            en_a;
    logic            en_b;
    logic [2*UW-1:0] sf_prod;
    logic [2*UW-1:0] sg_prod;
    logic [2*UW-1:0] p_prod;
    logic [2*UW-1:0] q_prod;
    logic [2*UW-1:0] t_prod;

    logic            valid_a_reg;
    logic [UW-1:0]   sf_a_reg;
    logic [UW-1:0]   sg_a_reg;
    logic [UW-1:0]   p_a_reg;
    logic [UW-1:0]   v_a_reg;
    sector_t         sector_a_reg;
    logic [7:0]      hue_a_reg;

    logic            valid_b_reg;
    logic [UW-1:0]   q_b_reg;
    logic [UW-1:0]   t_b_reg;
    logic [UW-1:0]   p_b_reg;
    logic [UW-1:0]   v_b_reg;
    sector_t         sector_b_reg;
    logic [7:0]      hue_b_reg;

    // Stage A: S*F, S*(1-F) and V*(1-S)
    always_comb
    begin
        sf_prod = (2*UW)'(s_val) * (2*UW)'(f_val);
        sg_prod = (2*UW)'(s_val) * (2*UW)'(ONE - f_val);
        p_prod  = (2*UW)'(v_val) * (2*UW)'(ONE - s_val);
    end

    // Stage B: V*(1-S*F) and V*(1-S*(1-F))
    always_comb
    begin
        q_prod = (2*UW)'(v_a_reg) * (2*UW)'(ONE - sf_a_reg);
        t_prod = (2*UW)'(v_a_reg) * (2*UW)'(ONE - sg_a_reg);
    end

    // Hold each stage while its successor is full and stalled
    assign en_b     = !valid_b_reg || out_ready;
    assign en_a     = !valid_a_reg || en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            sf_a_reg     <= UW'(sf_prod >> FRACTION_BITS);
            sg_a_reg     <= UW'(sg_prod >> FRACTION_BITS);
            p_a_reg      <= UW'(p_prod >> FRACTION_BITS);
            v_a_reg      <= v_val;
            sector_a_reg <= sector;
            hue_a_reg    <= hue;
        end
        if (en_b && valid_a_reg)
        begin
            q_b_reg      <= UW'(q_prod >> FRACTION_BITS);
            t_b_reg      <= UW'(t_prod >> FRACTION_BITS);
            p_b_reg      <= p_a_reg;
            v_b_reg      <= v_a_reg;
            sector_b_reg <= sector_a_reg;
            hue_b_reg    <= hue_a_reg;
        end
    end

    assign out_valid  = valid_b_reg;
    assign v_term     = v_b_reg;
    assign p_term     = p_b_reg;
    assign q_term     = q_b_reg;
    assign t_term     = t_b_reg;
    assign sector_out = sector_b_reg;
    assign hue_out    = hue_b_reg;

endmodule

// ===== design/hsv_to_rgb_fixed_unit.sv =====
// Top level of the fixed-point HSV to RGB converter: stream ports and output stage.
// Depends on hsvrgb_pkg, hsvrgb_front and hsvrgb_terms.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: hue_in, sat_in, level; tuser: enhanced
//  m_axis    out        tdata: red_out, green_out, blue_out, derived_hue
//
// One transfer is taken per cycle while m_axis is not stalled; a result passes the
// lookup stage, two multiplier stages and the channel select register in turn.
// Each stage holds only while the stage after it is full and stalled, so a
// stall on m_axis backs up through the stages without dropping or repeating.
// Reset clears the valid bits only; there is no state across items.
`timescale 1ns / 1ps

module hsv_to_rgb_fixed_unit
    import hsvrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] hue_in, [23:16] sat_in, [31:24] level
    input  logic        s_axis_tuser,   // [0] enhanced
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [15:0] red_out, [31:16] green_out,
                                        // [47:32] blue_out, [55:48] derived_hue
);

    localparam int UW = FRACTION_BITS + 1;

    logic          front_valid;
    logic          front_ready;
    logic [UW-1:0] front_v;
    logic [UW-1:0] front_s;
    logic [UW-1:0] front_f;
    sector_t       front_sector;
    logic [7:0]    front_hue;

    logic          terms_valid;
    logic          terms_ready;
    logic [UW-1:0] v_term;
    logic [UW-1:0] p_term;
    logic [UW-1:0] q_term;
    logic [UW-1:0] t_term;
    sector_t       terms_sector;
    logic [7:0]    terms_hue;

    logic [UW-1:0] red_sel;
    logic [UW-1:0] green_sel;
    logic [UW-1:0] blue_sel;

    logic          out_valid_reg;
    logic [15:0]   red_reg;
    logic [15:0]   green_reg;
    logic [15:0]   blue_reg;
    logic [7:0]    hue_reg;

    hsvrgb_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .hue_in    (s_axis_tdata[15:0]),
        .enhanced  (s_axis_tuser),
        .sat_in    (s_axis_tdata[23:16]),
        .level     (s_axis_tdata[31:24]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .v_val     (front_v),
        .s_val     (front_s),
        .f_val     (front_f),
        .sector    (front_sector),
        .hue       (front_hue)
    );

    hsvrgb_terms #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_terms (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (front_ready),
        .v_val      (front_v),
        .s_val      (front_s),
        .f_val      (front_f),
        .sector     (front_sector),
        .hue        (front_hue),
        .out_valid  (terms_valid),
        .out_ready  (terms_ready),
        .v_term     (v_term),
        .p_term     (p_term),
        .q_term     (q_term),
        .t_term     (t_term),
        .sector_out (terms_sector),
        .hue_out    (terms_hue)
    );

    // Route the terms to the channels by sector
    always_comb
    begin
        unique case (terms_sector)
            SECTOR_0:
            begin
                red_sel = v_term; green_sel = t_term; blue_sel = p_term;
            end
            SECTOR_1:
            begin
                red_sel = q_term; green_sel = v_term; blue_sel = p_term;
            end
            SECTOR_2:
            begin
                red_sel = p_term; green_sel = v_term; blue_sel = t_term;
            end
            SECTOR_3:
            begin
                red_sel = p_term; green_sel = q_term; blue_sel = v_term;
            end
            SECTOR_4:
            begin
                red_sel = t_term; green_sel = p_term; blue_sel = v_term;
            end
            default:
            begin
                red_sel = v_term; green_sel = p_term; blue_sel = q_term;
            end
        endcase
    end

    // Output register: take a new result whenever the held one is gone
    assign terms_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (terms_ready)
        begin
            out_valid_reg <= terms_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (terms_ready && terms_valid)
        begin
            red_reg   <= 16'(red_sel);
            green_reg <= 16'(green_sel);
            blue_reg  <= 16'(blue_sel);
            hue_reg   <= terms_hue;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {hue_reg, blue_reg, green_reg, red_reg};

endmodule
